### src/feedback_echo_comb_filter_defines.svh
// ---------------------------------------------------------------------------
// feedback echo comb filter: assertion macros
// property wrappers on clock and synchronous reset, removable with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef FEEDBACK_ECHO_COMB_FILTER_DEFINES_SVH
`define FEEDBACK_ECHO_COMB_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FECF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fecf: assertion failed");
`define FECF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("fecf: forbidden condition seen");
`else
`define FECF_ASSERT(label, clk, rst, prop)
`define FECF_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### src/fecf_pkg.sv
// ---------------------------------------------------------------------------
// fecf_pkg
// shared types and constants of the feedback echo comb filter
// ---------------------------------------------------------------------------
package fecf_pkg;

   localparam int DEF_MAX_DELAY   = 65536;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int CFG_W    = 16;   // width of every control register
   localparam int CSR_IDX_W = 2;
   localparam int CNT_W    = 17;   // pointer and counters, hold a full delay
   localparam int GAIN_W   = 17;   // gain as a signed multiplier operand
   localparam int X_SHIFT  = 12;   // input brought to the 12 fraction bit scale
   localparam int LO_BITS  = 16;   // low part of the sum for the split product
   localparam int ROUND_BIT = 27;
   localparam int OUT_SHIFT = 28;

   localparam logic [CFG_W-1:0] RST_DELAY = 16'd44100;
   localparam logic [CFG_W-1:0] RST_MIX   = 16'd2867;
   localparam logic [CFG_W-1:0] RST_NORM  = 16'd38550;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY = 2'd0,
      CSR_MIX   = 2'd1,
      CSR_NORM  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_SUM,
      ST_HI,
      ST_LO,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RES_PASS,
      RES_MEM,
      RES_CALC
   } res_type;

   typedef enum logic [1:0] {
      MUL_MIX,
      MUL_HI,
      MUL_LO
   } mul_sel_type;

   typedef struct packed {
      logic        en;
      mul_sel_type sel;
   } mul_ctrl_type;

endpackage

### src/fecf_ram.sv
// ---------------------------------------------------------------------------
// fecf_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module fecf_ram
   #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
   )
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fecf_mul.sv
// ---------------------------------------------------------------------------
// fecf_mul
// shared signed multiplier with operand select and registered product
// ---------------------------------------------------------------------------
module fecf_mul
   import fecf_pkg::*;
   #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
   )
   (
   input  logic                                   clock,
   input  mul_ctrl_type                           ctrl,
   input  logic signed [SAMPLE_BITS-1:0]          dly_data,
   input  logic [CFG_W-1:0]                       mix_gain,
   input  logic [CFG_W-1:0]                       norm_gain,
   input  logic signed [SAMPLE_BITS+17:0]         sum_val,
   output logic signed [((SAMPLE_BITS+2 > GAIN_W) ? SAMPLE_BITS+2 : GAIN_W)
                        + GAIN_W - 1:0]           prod
   );

   localparam int A_W   = (SAMPLE_BITS + 2 > GAIN_W) ? SAMPLE_BITS + 2 : GAIN_W;
   localparam int P_W   = A_W + GAIN_W;
   localparam int SUM_W = SAMPLE_BITS + 18;
   localparam int HI_W  = SUM_W - LO_BITS;

   logic signed [A_W-1:0]    op_a;
   logic signed [GAIN_W-1:0] op_b;
   logic signed [HI_W-1:0]   sum_hi;
   logic signed [P_W-1:0]    prod_ff;
   logic signed [P_W-1:0]    prod_in;

   // floor of sum / 2^16 is the arithmetic top part
   assign sum_hi = sum_val[SUM_W-1:LO_BITS];

   always_comb begin
      case (ctrl.sel)
         MUL_MIX: begin
            op_a = A_W'(dly_data);
            op_b = {1'b0, mix_gain};
         end
         MUL_HI: begin
            op_a = A_W'(sum_hi);
            op_b = {1'b0, norm_gain};
         end
         MUL_LO: begin
            op_a = A_W'({1'b0, sum_val[LO_BITS-1:0]});
            op_b = {1'b0, norm_gain};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### src/feedback_echo_comb_filter.sv
// A pass-through or drain item goes from the accepting edge to the done state, an echo
// sample first through the mix, sum, hi and lo states; done registers the result into
// rsp_valid and waits while rsp_ready is low. Drains that give no result stay idle.
// A new request is taken only when idle; an echo makes three passes through the one
// shared multiplier plus the final add. Reset: synchronous, clears pointer, counters,
// handshake state, restores control defaults; the delay line keeps contents, uncleared.
// ---------------------------------------------------------------------------
// feedback_echo_comb_filter
// feedback echo on a mono sample stream: delay line ram, shared multiplier
// and a small sequencer, with a registered result stage
// ---------------------------------------------------------------------------
`include "feedback_echo_comb_filter_defines.svh"

module feedback_echo_comb_filter
   import fecf_pkg::*;
   #(
   parameter int MAX_DELAY   = DEF_MAX_DELAY,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
   )
   (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]              csr_wr_data
   );

   localparam int ADDR_W = $clog2(MAX_DELAY);
   localparam int A_W    = (SAMPLE_BITS + 2 > GAIN_W) ? SAMPLE_BITS + 2 : GAIN_W;
   localparam int P_W    = A_W + GAIN_W;
   localparam int SUM_W  = SAMPLE_BITS + 18;
   localparam int T_W    = P_W + GAIN_W;
   localparam logic signed [T_W-1:0] SAT_HI =
      T_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [T_W-1:0] SAT_LO = ~SAT_HI;

   // control registers
   logic [CFG_W-1:0] cfg_delay_ff;
   logic [CFG_W-1:0] cfg_mix_ff;
   logic [CFG_W-1:0] cfg_norm_ff;

   // stream state
   logic [CNT_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] drain_ff, drain_in;
   logic             draining_ff, draining_in;

   // item in flight
   state_type                    state_ff, state_in;
   res_type                      kind_ff, kind_in;
   logic                         last_ff, last_in;
   logic [ADDR_W-1:0]            wr_addr_ff, wr_addr_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic signed [P_W-1:0]        acc_ff;

   // result stage
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_last_ff;

   logic                          accept;
   logic                          has_res;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic                          mem_wr_en;
   logic                          done_go;
   logic [CNT_W-1:0]              d_eff;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic signed [SAMPLE_BITS-1:0] y_res;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic signed [T_W-1:0]         total;
   logic signed [T_W-1:0]         y_full;
   logic signed [P_W-1:0]         prod;
   logic signed [SUM_W-1:0]       sum_in;
   mul_ctrl_type                  mul_ctrl;

   assign accept = req_valid && req_ready;

   // effective delay: zero counts as one, never beyond the ram depth
   always_comb begin
      d_eff = CNT_W'(cfg_delay_ff);
      if (cfg_delay_ff == '0) begin
         d_eff = CNT_W'(1);
      end else if ((MAX_DELAY < (1 << CFG_W)) && (32'(cfg_delay_ff) > MAX_DELAY)) begin
         d_eff = CNT_W'(MAX_DELAY);
      end
   end

   // item decode at the accepting edge
   always_comb begin
      logic [CNT_W-1:0] ptr_n;
      logic [CNT_W-1:0] fill_n;
      logic [CNT_W-1:0] drain_n;
      logic [CNT_W-1:0] rem;
      logic [CNT_W-1:0] rem_dec;
      logic [CNT_W-1:0] p;
      logic [CNT_W-1:0] f;
      logic [CNT_W:0]   idx;
      logic [CNT_W:0]   p_inc;

      ptr_n   = (wp_ff >= d_eff) ? '0 : wp_ff;
      fill_n  = (fill_ff > d_eff) ? d_eff : fill_ff;
      drain_n = (drain_ff > d_eff) ? d_eff : drain_ff;
      rem     = draining_ff ? drain_n : fill_n;
      rem_dec = rem - CNT_W'(1);
      p       = draining_ff ? '0 : ptr_n;
      f       = draining_ff ? '0 : fill_n;
      // oldest stored entry, one compare and subtract keeps it in the ring
      idx = {1'b0, ptr_n} + {1'b0, d_eff} - {1'b0, rem};
      if (idx >= {1'b0, d_eff}) begin
         idx = idx - {1'b0, d_eff};
      end
      p_inc = {1'b0, p} + (CNT_W + 1)'(1);

      wp_in       = wp_ff;
      fill_in     = fill_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      has_res     = 1'b0;
      kind_in     = kind_ff;
      last_in     = last_ff;
      wr_addr_in  = wr_addr_ff;
      rd_en       = 1'b0;
      rd_addr     = ADDR_W'(ptr_n);

      if (accept) begin
         wp_in    = ptr_n;
         fill_in  = fill_n;
         drain_in = drain_n;
         if (req_command) begin
            if (!draining_ff && (fill_n == '0)) begin
               // nothing stored, drain ignored
            end else if (rem == '0) begin
               wp_in       = '0;
               fill_in     = '0;
               drain_in    = '0;
               draining_in = 1'b0;
            end else begin
               has_res = 1'b1;
               kind_in = RES_MEM;
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(idx[CNT_W-1:0]);
               last_in = (rem_dec == '0);
               if (rem_dec == '0) begin
                  wp_in       = '0;
                  fill_in     = '0;
                  drain_in    = '0;
                  draining_in = 1'b0;
               end else begin
                  drain_in    = rem_dec;
                  draining_in = 1'b1;
               end
            end
         end else begin
            // a sample abandons any drain, and after a drain it starts a fresh stream
            has_res     = 1'b1;
            last_in     = 1'b0;
            draining_in = 1'b0;
            drain_in    = draining_ff ? '0 : drain_n;
            wr_addr_in  = ADDR_W'(p);
            wp_in       = (p_inc >= {1'b0, d_eff}) ? '0 : p_inc[CNT_W-1:0];
            if (f < d_eff) begin
               kind_in = RES_PASS;
               fill_in = f + CNT_W'(1);
            end else begin
               kind_in = RES_CALC;
               fill_in = f;
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(p);
            end
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && has_res) begin
               state_in = (kind_in == RES_CALC) ? ST_MIX : ST_DONE;
            end
         end
         ST_MIX:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_HI;
         ST_HI:   state_in = ST_LO;
         ST_LO:   state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      done_go      = 1'b0;
      mul_ctrl.en  = 1'b0;
      mul_ctrl.sel = MUL_MIX;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MIX: begin
            mul_ctrl.en  = 1'b1;
            mul_ctrl.sel = MUL_MIX;
         end
         ST_SUM: begin
            mul_ctrl.sel = MUL_HI;
         end
         ST_HI: begin
            mul_ctrl.en  = 1'b1;
            mul_ctrl.sel = MUL_HI;
         end
         ST_LO: begin
            mul_ctrl.en  = 1'b1;
            mul_ctrl.sel = MUL_LO;
         end
         ST_DONE: done_go = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign mem_wr_en = done_go && (kind_ff != RES_MEM);

   // y = floor((hi*norm*2^16 + lo*norm + 2^27) / 2^28), then saturate
   assign total  = (T_W'(acc_ff) <<< LO_BITS) + T_W'(prod)
                   + (T_W'(1) <<< ROUND_BIT);
   assign y_full = total >>> OUT_SHIFT;
   assign y_sat  = (y_full > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (y_full < SAT_LO) ? SAMPLE_BITS'(SAT_LO) :
                   y_full[SAMPLE_BITS-1:0];

   always_comb begin
      case (kind_ff)
         RES_PASS: y_res = x_ff;
         RES_MEM:  y_res = rd_data;
         RES_CALC: y_res = y_sat;
         default:  y_res = x_ff;
      endcase
   end

   assign sum_in = $signed(prod[SUM_W-1:0]) + (SUM_W'(x_ff) <<< X_SHIFT);

   fecf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_DELAY)
   ) u_delay_line (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (y_res),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fecf_mul #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mul (
      .clock     (clock),
      .ctrl      (mul_ctrl),
      .dly_data  (rd_data),
      .mix_gain  (cfg_mix_ff),
      .norm_gain (cfg_norm_ff),
      .sum_val   (sum_ff),
      .prod      (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_delay_ff <= RST_DELAY;
         cfg_mix_ff   <= RST_MIX;
         cfg_norm_ff  <= RST_NORM;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DELAY: cfg_delay_ff <= csr_wr_data;
            CSR_MIX:   cfg_mix_ff   <= csr_wr_data;
            CSR_NORM:  cfg_norm_ff  <= csr_wr_data;
            default:   cfg_delay_ff <= cfg_delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         fill_ff     <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      last_ff    <= last_in;
      wr_addr_ff <= wr_addr_in;
      if (accept) begin
         x_ff <= req_sample_in;
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_in;
      end
      if (state_ff == ST_LO) begin
         acc_ff <= prod;
      end
      if (done_go) begin
         rsp_sample_ff <= y_res;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;

   // single ram port pair: a read and a write never share a cycle
   `FECF_ASSERT_NEVER(a_no_rd_wr_clash, clock, reset, rd_en && mem_wr_en)
   `FECF_ASSERT(a_drain_within_fill, clock, reset, draining_ff |-> (drain_ff <= fill_ff))
   `FECF_ASSERT(a_done_gives_transfer, clock, reset, done_go |=> rsp_valid_ff)
   `FECF_ASSERT(a_mix_only_on_echo, clock, reset, (state_ff == ST_MIX) |-> (kind_ff == RES_CALC))

endmodule
